>>> design/caldate_pkg.sv
// Shared types, constants and helpers for the calendar date counter.
// No dependencies; used by calendar_date_counter and the testbench.
package caldate_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_ADV1 = 2'd1,
    OP_ADVN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_MONTH = 2'd1,
    ERR_YEAR  = 2'd2,
    ERR_DAY   = 2'd3
  } err_t;

  localparam logic [3:0]  MONTH_MIN = 4'd1;
  localparam logic [3:0]  MONTH_MAX = 4'd12;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [11:0] YEAR_MIN  = 12'd1900;
  localparam logic [11:0] YEAR_MAX  = 12'd2100;
  // multiples of 400 used as bases for year mod 400 over the settable year range
  localparam logic [11:0] YEAR_400_LO = 12'd1600;
  localparam logic [11:0] YEAR_400_HI = 12'd2000;
  localparam logic [9:0]  LEAP_DIV  = 10'd400;
  localparam logic [8:0]  CENT_1    = 9'd100;
  localparam logic [8:0]  CENT_2    = 9'd200;
  localparam logic [8:0]  CENT_3    = 9'd300;
  localparam logic [4:0]  FEB_LEAP  = 5'd29;

  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = MONTH_LEN[m];
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP;
    end
    return len;
  endfunction

endpackage

>>> design/calendar_date_counter.sv
// Gregorian date counter: set, advance one day, advance by a day count.
// One shared compare/subtract datapath under a small sequencer; uses caldate_pkg.
//
// Usage: one item at a time; s_axis_tready is high only while the block is idle and
// drops until the result item has been taken on the master side, so the next item
// can be accepted in the cycle after that. A set with a bad month or year, a count
// of zero and the unused operation code go straight to the result; any other set
// first checks the day in ST_SETDAY; advance by one day or by n days repeats
// ST_STEP, which moves at most to the start of the next month per pass, until the
// rest of the count fits in the current month. The leap flag follows a year-mod-400
// register that is loaded when a set passes its month and year checks and stepped
// on each year change. After reset the date is January 1, 1900; no clearing pass is needed.
module calendar_date_counter #(
  parameter int ADD_COUNT_WIDTH = 16,
  parameter int YEAR_WIDTH      = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] new_month, [8:4] new_day, [20:9] new_year, [36:21] days_to_add, rest zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] cur_month, [8:4] cur_day, [20:9] cur_year, rest zero
  output logic [23:0] m_axis_tdata,
  // [1:0] error_code
  output logic [1:0]  m_axis_tuser
);

  localparam int ExtW = (ADD_COUNT_WIDTH > 16) ? ADD_COUNT_WIDTH : 16;
  localparam int CmpW = (ADD_COUNT_WIDTH > 6) ? ADD_COUNT_WIDTH : 6;
  localparam logic [8:0] RemLast = 9'(caldate_pkg::LEAP_DIV - 10'd1);
  localparam logic [8:0] RemReset = 9'(caldate_pkg::YEAR_MIN - caldate_pkg::YEAR_400_LO);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETDAY = 4'b0010,
    ST_STEP   = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t                     state;
  caldate_pkg::err_t          err;
  logic [3:0]                 month;
  logic [4:0]                 day;
  logic [YEAR_WIDTH-1:0]      year;
  logic [4:0]                 set_day;
  logic [ADD_COUNT_WIDTH-1:0] cnt;
  // year modulo 400
  logic [8:0]                 rem;

  // input field views
  logic [3:0]                 in_month;
  logic [4:0]                 in_day;
  logic [11:0]                in_year;
  caldate_pkg::op_t           in_op;
  logic [ExtW-1:0]            add_ext;
  logic [ADD_COUNT_WIDTH-1:0] cnt_load;
  logic                       in_month_bad;
  logic                       in_year_bad;

  // shared datapath
  logic                       leap;
  logic [4:0]                 cur_len;
  logic [4:0]                 to_end;
  logic [CmpW-1:0]            cnt_ext;
  logic [CmpW-1:0]            step_ext;
  logic                       fits;
  logic [ADD_COUNT_WIDTH-1:0] cnt_next;
  logic [8:0]                 rem_set;
  logic [8:0]                 rem_inc;

  assign in_month = s_axis_tdata[3:0];
  assign in_day   = s_axis_tdata[8:4];
  assign in_year  = s_axis_tdata[20:9];
  assign in_op    = caldate_pkg::op_t'(s_axis_tuser);
  assign add_ext  = ExtW'(s_axis_tdata[36:21]);
  assign cnt_load = add_ext[ADD_COUNT_WIDTH-1:0];

  assign in_month_bad = (in_month < caldate_pkg::MONTH_MIN) ||
                        (in_month > caldate_pkg::MONTH_MAX);
  assign in_year_bad  = (in_year < caldate_pkg::YEAR_MIN) ||
                        (in_year > caldate_pkg::YEAR_MAX);

  always_comb begin
    leap     = (rem == 9'd0) ||
               (rem != caldate_pkg::CENT_1 && rem != caldate_pkg::CENT_2 &&
                rem != caldate_pkg::CENT_3 && year[1:0] == 2'd0);
    cur_len  = caldate_pkg::month_len(month, leap);
    // a day left past month end by a failed set counts as the last day
    to_end   = (day < cur_len) ? 5'(cur_len - day) : 5'd0;
    cnt_ext  = CmpW'(cnt);
    step_ext = CmpW'(to_end) + CmpW'(1);
    fits     = cnt_ext <= CmpW'(to_end);
    cnt_next = ADD_COUNT_WIDTH'(cnt_ext - step_ext);
    // settable years lie in 1900..2100
    rem_set  = (in_year >= caldate_pkg::YEAR_400_HI) ?
               9'(in_year - caldate_pkg::YEAR_400_HI) :
               9'(in_year - caldate_pkg::YEAR_400_LO);
    // the year counter wraps to zero, which is a multiple of 400
    rem_inc  = ((&year) || rem == RemLast) ? 9'd0 : rem + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      month <= caldate_pkg::MONTH_MIN;
      day   <= 5'd1;
      year  <= YEAR_WIDTH'(caldate_pkg::YEAR_MIN);
      rem   <= RemReset;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            set_day <= in_day;
            case (in_op)
              caldate_pkg::OP_SET: begin
                if (in_month_bad) begin
                  err   <= caldate_pkg::ERR_MONTH;
                  state <= ST_OUT;
                end else if (in_year_bad) begin
                  month <= in_month;
                  err   <= caldate_pkg::ERR_YEAR;
                  state <= ST_OUT;
                end else begin
                  month <= in_month;
                  year  <= YEAR_WIDTH'(in_year);
                  rem   <= rem_set;
                  err   <= caldate_pkg::ERR_OK;
                  state <= ST_SETDAY;
                end
              end
              caldate_pkg::OP_ADV1: begin
                cnt   <= ADD_COUNT_WIDTH'(1);
                err   <= caldate_pkg::ERR_OK;
                state <= ST_STEP;
              end
              caldate_pkg::OP_ADVN: begin
                cnt   <= cnt_load;
                err   <= caldate_pkg::ERR_OK;
                state <= (cnt_load == '0) ? ST_OUT : ST_STEP;
              end
              default: begin
                err   <= caldate_pkg::ERR_OK;
                state <= ST_OUT;
              end
            endcase
          end
        end
        ST_SETDAY: begin
          if (set_day == 5'd0 || set_day > cur_len) begin
            err <= caldate_pkg::ERR_DAY;
          end else begin
            day <= set_day;
          end
          state <= ST_OUT;
        end
        ST_STEP: begin
          if (fits) begin
            day   <= day + cnt_ext[4:0];
            state <= ST_OUT;
          end else begin
            cnt <= cnt_next;
            day <= 5'd1;
            if (month < caldate_pkg::MONTH_MAX) begin
              month <= month + 4'd1;
            end else begin
              month <= caldate_pkg::MONTH_MIN;
              year  <= year + YEAR_WIDTH'(1);
              rem   <= rem_inc;
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {3'd0, year[11:0], day, month};
  assign m_axis_tuser  = err;

endmodule

>>> design/caldate_checker.sv
// Port-level checks for calendar_date_counter, bound to the top level.
// Depends on the top level's port list only.
module caldate_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one item in flight: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // accepting an item drops ready, so no second item is taken straight after it
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accepting an item");

  // once the result is taken the block is idle again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after result taken");

  // reported month is always a real month
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] >= 4'd1 && m_axis_tdata[3:0] <= 4'd12))
    else $error("month out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

endmodule

bind calendar_date_counter caldate_checker u_caldate_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/sv/testbench.sv
// Self-checking bench for calendar_date_counter: directed and random date items.
// A scoreboard class predicts each result; depends on caldate_pkg and the block.
module testbench;

  // Unused operation code: the block reports the date unchanged.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 950;

  class date_scoreboard;
    typedef struct packed {
      logic [3:0]  month;
      logic [4:0]  day;
      logic [11:0] year;
      logic [1:0]  err;
    } date_result_t;

    logic [3:0]  month_q;
    logic [4:0]  day_q;
    logic [11:0] year_q;
    date_result_t expected_dates[$];
    int failures;

    function new();
      month_q  = caldate_pkg::MONTH_MIN;
      day_q    = 5'd1;
      year_q   = caldate_pkg::YEAR_MIN;
      failures = 0;
    endfunction

    function bit leap_year(logic [11:0] y);
      int unsigned v;
      v = y;
      return (v % 400 == 0) || ((v % 100 != 0) && (v % 4 == 0));
    endfunction

    function int unsigned days_in_month(logic [3:0] m, logic [11:0] y);
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
        4'd4, 4'd6, 4'd9, 4'd11: return 30;
        caldate_pkg::MONTH_FEB: return leap_year(y) ? 29 : 28;
        default: return 0;
      endcase
    endfunction

    function void advance_days(int unsigned n);
      int unsigned len;
      int unsigned to_end;
      while (n > 0) begin
        len = days_in_month(month_q, year_q);
        to_end = (day_q < len) ? len - day_q : 0;
        if (n <= to_end) begin
          day_q = 5'(day_q + n);
          n = 0;
        end else begin
          n = n - to_end - 1;
          day_q = 5'd1;
          if (month_q < caldate_pkg::MONTH_MAX) begin
            month_q = month_q + 4'd1;
          end else begin
            month_q = caldate_pkg::MONTH_MIN;
            year_q  = year_q + 12'd1;
          end
        end
      end
    endfunction

    // Fields are checked month, year, day; an accepted field stays written.
    function logic [1:0] set_date(logic [3:0] m, logic [4:0] d, logic [11:0] y);
      if (m < caldate_pkg::MONTH_MIN || m > caldate_pkg::MONTH_MAX)
        return caldate_pkg::ERR_MONTH;
      month_q = m;
      if (y < caldate_pkg::YEAR_MIN || y > caldate_pkg::YEAR_MAX)
        return caldate_pkg::ERR_YEAR;
      year_q = y;
      if (d < 1 || d > days_in_month(month_q, year_q)) return caldate_pkg::ERR_DAY;
      day_q = d;
      return caldate_pkg::ERR_OK;
    endfunction

    function void note_input(logic [1:0] op, logic [39:0] data);
      date_result_t res;
      res.err = caldate_pkg::ERR_OK;
      case (op)
        caldate_pkg::OP_SET:  res.err = set_date(data[3:0], data[8:4], data[20:9]);
        caldate_pkg::OP_ADV1: advance_days(1);
        caldate_pkg::OP_ADVN: advance_days(32'(data[36:21]));
        default: ;
      endcase
      res.month = month_q;
      res.day   = day_q;
      res.year  = year_q;
      expected_dates.push_back(res);
    endfunction

    function void check_result(logic [23:0] data, logic [1:0] err);
      date_result_t exp_res;
      if (expected_dates.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result item: %0d/%0d/%0d err %0d",
                   data[3:0], data[8:4], data[20:9], err);
        return;
      end
      exp_res = expected_dates.pop_front();
      if (data[3:0] !== exp_res.month || data[8:4] !== exp_res.day ||
          data[20:9] !== exp_res.year || err !== exp_res.err) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %0d/%0d/%0d err %0d, got %0d/%0d/%0d err %0d",
                   exp_res.month, exp_res.day, exp_res.year, exp_res.err,
                   data[3:0], data[8:4], data[20:9], err);
      end
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int send_idle_pct = 32;
  int recv_idle_pct = 66;
  date_scoreboard sb;

  calendar_date_counter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic push_date_item(input logic [1:0] op, input logic [3:0] m,
                                input logic [4:0] d, input logic [11:0] y,
                                input logic [15:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, cnt, y, d, m};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(s_axis_tuser, s_axis_tdata);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    push_date_item(caldate_pkg::OP_SET, 4'd2, 5'd29, 12'd2000, 16'h0);   // leap by 400
    push_date_item(caldate_pkg::OP_SET, 4'd2, 5'd29, 12'd1900, 16'h0);   // century, not leap
    push_date_item(caldate_pkg::OP_SET, 4'd0, 5'd10, 12'd2000, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd15, 5'd10, 12'd2000, 16'h0);
    // month kept, year rejected
    push_date_item(caldate_pkg::OP_SET, 4'd4, 5'd10, 12'd1899, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd7, 5'd10, 12'd4095, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd7, 5'd0, 12'd2050, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd12, 5'd31, 12'd2100, 16'h0);
    push_date_item(caldate_pkg::OP_ADV1, 4'd0, 5'd0, 12'd0, 16'h0);      // year rollover
    // day left beyond the end of February counts as its last day
    push_date_item(caldate_pkg::OP_SET, 4'd1, 5'd31, 12'd2004, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd2, 5'd30, 12'd2004, 16'h0);
    push_date_item(caldate_pkg::OP_ADV1, 4'd0, 5'd0, 12'd0, 16'h0);
    push_date_item(caldate_pkg::OP_SET, 4'd2, 5'd28, 12'd2004, 16'h0);
    push_date_item(caldate_pkg::OP_ADV1, 4'd0, 5'd0, 12'd0, 16'h0);
    push_date_item(caldate_pkg::OP_ADV1, 4'd0, 5'd0, 12'd0, 16'h0);
    push_date_item(OP_NOP, 4'd0, 5'd0, 12'd0, 16'h0);
    push_date_item(caldate_pkg::OP_ADVN, 4'd0, 5'd0, 12'd0, 16'h0);
    // enough full-count advances from 2100 to wrap the year counter
    push_date_item(caldate_pkg::OP_SET, 4'd12, 5'd31, 12'd2100, 16'h0);
    repeat (12) push_date_item(caldate_pkg::OP_ADVN, 4'd0, 5'd0, 12'd0, 16'hFFFF);
    push_date_item(caldate_pkg::OP_SET, 4'd3, 5'd31, 12'd1899, 16'h0);
  endtask

  task automatic run_random();
    int unsigned pick;
    int unsigned len;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [11:0] y;
    logic [15:0] cnt;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct = 66;
        recv_idle_pct = 32;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      cnt  = 16'($urandom);
      if (pick < 35) begin
        if ($urandom_range(3) != 0) begin
          m = 4'($urandom_range(12, 1));
          y = 12'($urandom_range(2100, 1900));
          len = sb.days_in_month(m, y);
          case ($urandom_range(2))
            0: d = 5'(len);
            1: d = 5'(len - 1);
            default: d = 5'($urandom_range(len, 1));
          endcase
        end else begin
          m = 4'($urandom);
          d = 5'($urandom);
          y = 12'($urandom);
        end
        push_date_item(caldate_pkg::OP_SET, m, d, y, cnt);
      end else begin
        m = 4'($urandom);
        d = 5'($urandom);
        y = 12'($urandom);
        if (pick < 65) begin
          push_date_item(caldate_pkg::OP_ADV1, m, d, y, cnt);
        end else if (pick < 95) begin
          // full-range counts are slow, so they stay rare
          if ($urandom_range(39) != 0)
            cnt = $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom_range(400));
          push_date_item(caldate_pkg::OP_ADVN, m, d, y, cnt);
        end else begin
          push_date_item(OP_NOP, m, d, y, cnt);
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

endmodule
